// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/edr_pkg.sv
`default_nettype none

package edr_pkg;

   // channel and field widths
   localparam int NUM_CH       = 3;
   localparam int PIX_W        = 8;
   localparam int REF_W        = 16;
   localparam int LEVEL_W      = 16;
   localparam int LVL_W        = 17;
   localparam int SIGMA_W      = 16;
   localparam int EXP_W        = 5;
   localparam int SLOPE_W      = 16;
   localparam int SLOPE_FRAC_W = 8;
   localparam int FRAC_W       = 16;
   localparam int RATIO_W      = 17;
   localparam int EDGE_W       = SLOPE_W + LVL_W - SLOPE_FRAC_W;
   localparam int TERM_W       = EDGE_W + 1;

   // pipeline depths
   localparam int DIV_STAGES = RATIO_W;
   localparam int POW_STAGES = (1 << EXP_W) - 1;

   // bus widths
   localparam int REQ_W       = NUM_CH * (PIX_W + REF_W);
   localparam int RSP_W       = NUM_CH * PIX_W;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // arithmetic constants
   localparam logic [RATIO_W-1:0] ONE_Q16   = RATIO_W'(1) << FRAC_W;
   localparam logic [LEVEL_W-1:0] RECIP_257 = 16'd65281;

   // register defaults
   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd19661;
   localparam logic [EXP_W-1:0]   EXP_RESET   = 5'd15;
   localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd256;

   localparam int OUT_DEPTH_DEF = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIGMA    = 2'd0,
      CSR_EXPONENT = 2'd1,
      CSR_SLOPE    = 2'd2
   } csr_index_type;

   // per-channel values carried alongside the divider and power stages
   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic             neg;
      logic             is_detail;
      logic [LVL_W-1:0] diff;
   } chan_side_type;

endpackage

`default_nettype wire

// File: hw/rtl/edr_divider.sv
`default_nettype none

module edr_divider
   import edr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SIGMA_W-1:0]  in_mag   [NUM_CH],
   input  chan_side_type       in_side  [NUM_CH],
   input  logic [SIGMA_W-1:0]  sigma,
   output logic                out_valid,
   output logic [RATIO_W-1:0]  out_ratio [NUM_CH],
   output chan_side_type       out_side  [NUM_CH]
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [SIGMA_W-1:0]    rem_ff   [DIV_STAGES-1][NUM_CH];
   logic [SIGMA_W-1:0]    rem_in   [DIV_STAGES-1][NUM_CH];
   logic [RATIO_W-1:0]    quot_ff  [DIV_STAGES][NUM_CH];
   logic [RATIO_W-1:0]    quot_in  [DIV_STAGES][NUM_CH];
   chan_side_type         side_ff  [DIV_STAGES][NUM_CH];
   chan_side_type         side_in  [DIV_STAGES][NUM_CH];

   assign valid_in = {valid_ff[DIV_STAGES-2:0], in_valid};

   // one restoring step per stage, quotient msb first
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
         logic [RATIO_W-1:0] part;
         logic [RATIO_W-1:0] qprev;
         logic [RATIO_W:0]   trial;
         logic               ge;

         if (s == 0) begin : g_first
            assign part          = {1'b0, in_mag[c]};
            assign qprev         = '0;
            assign side_in[s][c] = in_side[c];
         end else begin : g_next
            assign part          = {rem_ff[s-1][c], 1'b0};
            assign qprev         = quot_ff[s-1][c];
            assign side_in[s][c] = side_ff[s-1][c];
         end

         assign trial = {1'b0, part} - {2'b0, sigma};
         assign ge    = ~trial[RATIO_W];
         assign quot_in[s][c] = qprev | (RATIO_W'(ge) << (DIV_STAGES - 1 - s));

         if (s < DIV_STAGES - 1) begin : g_rem
            assign rem_in[s][c] = ge ? trial[SIGMA_W-1:0] : part[SIGMA_W-1:0];
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_ratio = quot_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/edr_power.sv
`default_nettype none

module edr_power
   import edr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RATIO_W-1:0]  in_ratio [NUM_CH],
   input  chan_side_type       in_side  [NUM_CH],
   input  logic [EXP_W-1:0]    exponent,
   output logic                out_valid,
   output logic [RATIO_W-1:0]  out_power [NUM_CH],
   output chan_side_type       out_side  [NUM_CH]
);

   logic [POW_STAGES-1:0] valid_ff;
   logic [POW_STAGES-1:0] valid_in;
   logic [RATIO_W-1:0]    w_ff    [POW_STAGES][NUM_CH];
   logic [RATIO_W-1:0]    w_in    [POW_STAGES][NUM_CH];
   logic [RATIO_W-1:0]    t_ff    [POW_STAGES-1][NUM_CH];
   logic [RATIO_W-1:0]    t_in    [POW_STAGES-1][NUM_CH];
   chan_side_type         side_ff [POW_STAGES][NUM_CH];
   chan_side_type         side_in [POW_STAGES][NUM_CH];

   assign valid_in = {valid_ff[POW_STAGES-2:0], in_valid};

   // one truncating multiply per stage, skipped once the exponent is used up
   for (genvar s = 0; s < POW_STAGES; s++) begin : g_stage
      for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
         logic [RATIO_W-1:0]   wprev;
         logic [RATIO_W-1:0]   tprev;
         logic [2*RATIO_W-1:0] prod;

         if (s == 0) begin : g_first
            assign wprev         = ONE_Q16;
            assign tprev         = in_ratio[c];
            assign side_in[s][c] = in_side[c];
         end else begin : g_next
            assign wprev         = w_ff[s-1][c];
            assign tprev         = t_ff[s-1][c];
            assign side_in[s][c] = side_ff[s-1][c];
         end

         assign prod       = wprev * tprev;
         assign w_in[s][c] = (EXP_W'(s) < exponent) ? prod[FRAC_W+RATIO_W-1:FRAC_W] : wprev;

         if (s < POW_STAGES - 1) begin : g_ratio
            assign t_in[s][c] = tprev;
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff    <= w_in;
         t_ff    <= t_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[POW_STAGES-1];
   assign out_power = w_ff[POW_STAGES-1];
   assign out_side  = side_ff[POW_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/edr_out_fifo.sv
`default_nettype none

module edr_out_fifo
   import edr_pkg::*;
#(
   parameter int DEPTH = OUT_DEPTH_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [RSP_W-1:0] push_data,
   output logic             full,
   input  logic             pop_ready,
   output logic             out_valid,
   output logic [RSP_W-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [RSP_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;

   assign pop       = out_valid & pop_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/llf_detail_edge_remap.sv
// Detail/edge remapping of one three-channel pixel per request.
// req channel: tdata carries pix_b, pix_g, pix_r (8 bits each) and the
// Q8.8 references ref_b, ref_g, ref_r (16 bits each). rsp channel: tdata
// carries the remapped out_b, out_g, out_r (8 bits each).
// csr channel: write-only, csr_index selects sigma_frac (0), detail_exponent
// (1) or edge_slope (2); csr_ready is always high. The user must write the
// registers only while no request is in flight; the block does not enforce it.
// Throughput: one pixel per clock while the result buffer is not full. Path:
// three input arithmetic stages, the 17-stage quotient divider, the 31
// multiplier stages of the power chain and four output arithmetic stages,
// then the result buffer.
// A two-entry result buffer sits at the output. When the receiver holds
// rsp_tready low the buffer fills, then req_tready drops and the whole
// pipeline freezes in place until the buffer is no longer full.
// Reset empties the pipeline and the buffer and loads the registers with
// sigma 19661, exponent 15 and slope 256.
`default_nettype none

module llf_detail_edge_remap
   import edr_pkg::*;
#(
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // pix_b, pix_g, pix_r, ref_b, ref_g, ref_r
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,
   // out_b, out_g, out_r
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [SIGMA_W-1:0] sigma_ff;
   logic [EXP_W-1:0]   exponent_ff;
   logic [SLOPE_W-1:0] slope_ff;

   logic en;
   logic fifo_full;

   // front stages
   logic               v0_ff, v1_ff, v2_ff;
   logic [PIX_W-1:0]   pix0_ff  [NUM_CH];
   logic [REF_W-1:0]   ref0_ff  [NUM_CH];
   logic [LVL_W-1:0]   lvl1_ff  [NUM_CH];
   logic [LVL_W-1:0]   lvl1_in  [NUM_CH];
   logic               neg1_ff  [NUM_CH];
   logic               neg1_in  [NUM_CH];
   logic [LVL_W-1:0]   mag1_ff  [NUM_CH];
   logic [LVL_W-1:0]   mag1_in  [NUM_CH];
   logic [SIGMA_W-1:0] mag2_ff  [NUM_CH];
   logic [SIGMA_W-1:0] mag2_in  [NUM_CH];
   chan_side_type      side2_ff [NUM_CH];
   chan_side_type      side2_in [NUM_CH];

   // divider and power chain
   logic               div_valid;
   logic [RATIO_W-1:0] div_ratio [NUM_CH];
   chan_side_type      div_side  [NUM_CH];
   logic               pow_valid;
   logic [RATIO_W-1:0] pow_w     [NUM_CH];
   chan_side_type      pow_side  [NUM_CH];

   // back stages
   logic               ve1_ff, ve2_ff, ve3_ff, ve4_ff;
   logic [SIGMA_W-1:0] detail1_ff [NUM_CH];
   logic [SIGMA_W-1:0] detail1_in [NUM_CH];
   logic [EDGE_W-1:0]  edge1_ff   [NUM_CH];
   logic [EDGE_W-1:0]  edge1_in   [NUM_CH];
   logic [LVL_W-1:0]   lvle1_ff   [NUM_CH];
   logic               nege1_ff   [NUM_CH];
   logic               dete1_ff   [NUM_CH];
   logic [TERM_W-1:0]  term2_ff   [NUM_CH];
   logic [TERM_W-1:0]  term2_in   [NUM_CH];
   logic [LVL_W-1:0]   lvle2_ff   [NUM_CH];
   logic               nege2_ff   [NUM_CH];
   logic [LEVEL_W-1:0] res3_ff    [NUM_CH];
   logic [LEVEL_W-1:0] res3_in    [NUM_CH];
   logic [PIX_W-1:0]   out4_ff    [NUM_CH];
   logic [PIX_W-1:0]   out4_in    [NUM_CH];
   logic [RSP_W-1:0]   push_data;

   assign en         = ~fifo_full;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff    <= SIGMA_RESET;
         exponent_ff <= EXP_RESET;
         slope_ff    <= SLOPE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIGMA:    sigma_ff    <= csr_data[SIGMA_W-1:0];
            CSR_EXPONENT: exponent_ff <= csr_data[EXP_W-1:0];
            CSR_SLOPE:    slope_ff    <= csr_data[SLOPE_W-1:0];
            default:      ;
         endcase
      end
   end

   // reference level and absolute difference
   always_comb begin : lvl_diff
      logic [2*PIX_W-1:0] pix_lvl;
      logic [LVL_W:0]     dlt;
      for (int c = 0; c < NUM_CH; c++) begin
         pix_lvl    = {pix0_ff[c], pix0_ff[c]};
         lvl1_in[c] = {1'b0, ref0_ff[c]} + LVL_W'(ref0_ff[c][REF_W-1:PIX_W]);
         dlt        = {2'b0, pix_lvl} - {1'b0, lvl1_in[c]};
         neg1_in[c] = dlt[LVL_W];
         mag1_in[c] = dlt[LVL_W] ? LVL_W'(-dlt) : dlt[LVL_W-1:0];
      end
   end

   // detail or edge decision
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         side2_in[c].lvl       = lvl1_ff[c];
         side2_in[c].neg       = neg1_ff[c];
         side2_in[c].is_detail = (mag1_ff[c] <= {1'b0, sigma_ff});
         side2_in[c].diff      = mag1_ff[c] - {1'b0, sigma_ff};
         mag2_in[c]            = mag1_ff[c][SIGMA_W-1:0];
      end
   end

   // front valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // front payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < NUM_CH; c++) begin
            pix0_ff[c] <= req_tdata[c*PIX_W +: PIX_W];
            ref0_ff[c] <= req_tdata[NUM_CH*PIX_W + c*REF_W +: REF_W];
         end
         lvl1_ff  <= lvl1_in;
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         mag2_ff  <= mag2_in;
         side2_ff <= side2_in;
      end
   end

   // normalised ratio |d| / sigma
   edr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_mag    (mag2_ff),
      .in_side   (side2_ff),
      .sigma     (sigma_ff),
      .out_valid (div_valid),
      .out_ratio (div_ratio),
      .out_side  (div_side)
   );

   // integer power of the ratio
   edr_power u_power (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_ratio  (div_ratio),
      .in_side   (div_side),
      .exponent  (exponent_ff),
      .out_valid (pow_valid),
      .out_power (pow_w),
      .out_side  (pow_side)
   );

   // detail and edge products
   always_comb begin : products
      logic [SIGMA_W+RATIO_W-1:0] sprod;
      logic [SLOPE_W+LVL_W-1:0]   eprod;
      for (int c = 0; c < NUM_CH; c++) begin
         sprod         = sigma_ff * pow_w[c];
         eprod         = slope_ff * pow_side[c].diff;
         detail1_in[c] = sprod[FRAC_W+SIGMA_W-1:FRAC_W];
         edge1_in[c]   = eprod[SLOPE_W+LVL_W-1:SLOPE_FRAC_W];
      end
   end

   // term selection
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         term2_in[c] = dete1_ff[c] ? TERM_W'(detail1_ff[c])
                                   : TERM_W'(edge1_ff[c]) + TERM_W'(sigma_ff);
      end
   end

   // signed offset from the reference and clamp to full scale
   always_comb begin : offset_clamp
      logic [TERM_W+1:0] lev;
      for (int c = 0; c < NUM_CH; c++) begin
         lev = nege2_ff[c] ? (TERM_W+2)'(lvle2_ff[c]) - (TERM_W+2)'(term2_ff[c])
                           : (TERM_W+2)'(lvle2_ff[c]) + (TERM_W+2)'(term2_ff[c]);
         if (lev[TERM_W+1]) begin
            res3_in[c] = '0;
         end else if (|lev[TERM_W:LEVEL_W]) begin
            res3_in[c] = '1;
         end else begin
            res3_in[c] = lev[LEVEL_W-1:0];
         end
      end
   end

   // level / 257 by reciprocal multiply
   always_comb begin : to_pixel
      logic [2*LEVEL_W-1:0] qprod;
      for (int c = 0; c < NUM_CH; c++) begin
         qprod      = res3_ff[c] * RECIP_257;
         out4_in[c] = qprod[2*LEVEL_W-1 -: PIX_W];
      end
   end

   // back valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         ve1_ff <= 1'b0;
         ve2_ff <= 1'b0;
         ve3_ff <= 1'b0;
         ve4_ff <= 1'b0;
      end else if (en) begin
         ve1_ff <= pow_valid;
         ve2_ff <= ve1_ff;
         ve3_ff <= ve2_ff;
         ve4_ff <= ve3_ff;
      end
   end

   // back payload
   always_ff @(posedge clock) begin
      if (en) begin
         detail1_ff <= detail1_in;
         edge1_ff   <= edge1_in;
         for (int c = 0; c < NUM_CH; c++) begin
            lvle1_ff[c] <= pow_side[c].lvl;
            nege1_ff[c] <= pow_side[c].neg;
            dete1_ff[c] <= pow_side[c].is_detail;
         end
         term2_ff <= term2_in;
         lvle2_ff <= lvle1_ff;
         nege2_ff <= nege1_ff;
         res3_ff  <= res3_in;
         out4_ff  <= out4_in;
      end
   end

   // result packing
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         push_data[c*PIX_W +: PIX_W] = out4_ff[c];
      end
   end

   // output buffer
   edr_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (en & ve4_ff),
      .push_data (push_data),
      .full      (fifo_full),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/edr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module edr_checker
   import edr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // a held result keeps its value
   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // reset leaves an empty buffer ready for requests
   `ASSERT_NEXT(reset_empty_a, clock, 1'b0, reset, req_tready && !rsp_tvalid)

   // the pipeline only stalls behind a pending result
   `ASSERT_IMPLY(stall_cause_a, clock, reset, !req_tready, rsp_tvalid)

   // the buffer fills only while the receiver holds off
   `ASSERT_IMPLY(fill_cause_a, clock, reset, $fell(req_tready), $past(rsp_tvalid && !rsp_tready))

endmodule

bind llf_detail_edge_remap edr_checker u_edr_checker (.*);

`default_nettype wire

// File: tb/tb_llf_detail_edge_remap.sv
`timescale 1ns / 100ps

module tb_llf_detail_edge_remap;
   import edr_pkg::*;

   localparam int PIPE_LATENCY   = 55;
   localparam int TAIL_CYCLES    = 2 * PIPE_LATENCY;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int NUM_PHASES     = 10;
   localparam int PHASE_REQUESTS = 193;
   localparam int MAX_GAP        = 14;

   // index with no register behind it, written once to see it ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // request and response layouts, last declared field in the lowest bits
   typedef struct packed {
      logic [REF_W-1:0] ref_r;
      logic [REF_W-1:0] ref_g;
      logic [REF_W-1:0] ref_b;
      logic [PIX_W-1:0] pix_r;
      logic [PIX_W-1:0] pix_g;
      logic [PIX_W-1:0] pix_b;
   } pixel_in_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_r;
      logic [PIX_W-1:0] out_g;
      logic [PIX_W-1:0] out_b;
   } pixel_out_type;

   // remap predictor and queue of expected pixels
   class remap_scoreboard;
      logic [SIGMA_W-1:0] sigma;
      logic [EXP_W-1:0]   power_n;
      logic [SLOPE_W-1:0] slope;
      pixel_out_type      expected_pixels[$];
      int                 failures;

      function new();
         sigma    = SIGMA_RESET;
         power_n  = EXP_RESET;
         slope    = SLOPE_RESET;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SIGMA:    sigma   = value[SIGMA_W-1:0];
            CSR_EXPONENT: power_n = value[EXP_W-1:0];
            CSR_SLOPE:    slope   = value[SLOPE_W-1:0];
            default: ;
         endcase
      endfunction

      // one channel through the detail/edge curve
      function logic [PIX_W-1:0] remap_sample(logic [PIX_W-1:0] pix,
                                              logic [REF_W-1:0] anchor);
         longint          lvl_p;
         longint          lvl_g;
         longint          diff;
         longint          remapped;
         longint unsigned mag;
         longint unsigned sig;
         longint unsigned gain;
         longint unsigned ratio;
         longint unsigned power;
         longint unsigned term;
         lvl_p = longint'(pix) * 257;
         lvl_g = (longint'(anchor) * 257) >> 8;
         diff  = lvl_p - lvl_g;
         mag   = (diff < 0) ? -diff : diff;
         sig   = sigma;
         gain  = slope;
         if (mag <= sig) begin
            // detail: sigma * (mag / sigma)^n in Q1.16
            if (sig == 0) begin
               term = 0;
            end else begin
               ratio = (mag << 16) / sig;
               power = 64'd65536;
               for (int i = 0; i < power_n; i++)
                  power = (power * ratio) >> 16;
               term = (sig * power) >> 16;
            end
         end else begin
            // edge: linear gain beyond sigma
            term = ((gain * (mag - sig)) >> 8) + sig;
         end
         remapped = (diff >= 0) ? lvl_g + longint'(term) : lvl_g - longint'(term);
         if (remapped < 0)
            remapped = 0;
         if (remapped > 65535)
            remapped = 65535;
         return PIX_W'(remapped / 257);
      endfunction

      function void note_request(pixel_in_type px);
         pixel_out_type want;
         want.out_b = remap_sample(px.pix_b, px.ref_b);
         want.out_g = remap_sample(px.pix_g, px.ref_g);
         want.out_r = remap_sample(px.pix_r, px.ref_r);
         expected_pixels.push_back(want);
      endfunction

      function void compare_field(string name, logic [PIX_W-1:0] want,
                                  logic [PIX_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(pixel_out_type got);
         pixel_out_type want;
         if (expected_pixels.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            failures++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("out_b", want.out_b, got.out_b);
            compare_field("out_g", want.out_g, got.out_g);
            compare_field("out_r", want.out_r, got.out_r);
         end
      endfunction

      function int pending_count();
         return expected_pixels.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   remap_scoreboard board;
   bit              req_burst = 1'b0;
   bit              rsp_burst = 1'b0;
   int              rsp_hold = 0;
   int              cycle_count = 0;

   llf_detail_edge_remap dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: check each pixel, then, outside bursts, stall for a random while
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata);
            if ($urandom_range(0, 63) == 0)
               rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   task automatic send_pixel(input pixel_in_type px);
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(px);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(index, value);
      csr_valid <= 1'b0;
      // go idle before the next write
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] sigma_val,
                                 input logic [CSR_DATA_W-1:0] exp_val,
                                 input logic [CSR_DATA_W-1:0] slope_val);
      write_csr(CSR_SIGMA, sigma_val);
      write_csr(CSR_EXPONENT, exp_val);
      write_csr(CSR_SLOPE, slope_val);
   endtask

   // hold off new requests until every pixel in flight has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_count() != 0) @(posedge clock);
   endtask

   // q8.8 anchor whose level lands on or next to the wanted level
   function automatic logic [REF_W-1:0] anchor_for_level(input int level);
      int value;
      if (level < 0)
         level = 0;
      value = (level * 256 + 256) / 257;
      if (value > 65535)
         value = 65535;
      return REF_W'(value);
   endfunction

   // anchors mostly around the pixel so both branches of the curve get hit
   function automatic logic [REF_W-1:0] pick_anchor(input logic [PIX_W-1:0] pix,
                                                    input int sig);
      int kind;
      int spread;
      int level;
      kind = $urandom_range(0, 9);
      case (kind)
         0:       return {pix, 8'h00};
         1, 2, 3: spread = $urandom_range(0, sig);
         4:       spread = sig + $urandom_range(0, 4) - 2;
         5, 6, 7: return REF_W'($urandom_range(0, 65535));
         8:       return REF_W'($urandom_range(65280, 65535));
         default: return {pix, PIX_W'($urandom)};
      endcase
      level = int'(pix) * 257;
      level = $urandom_range(0, 1) ? level + spread : level - spread;
      return anchor_for_level(level + $urandom_range(0, 2) - 1);
   endfunction

   function automatic pixel_in_type make_pixel(input int pb, input int pg, input int pr,
                                               input int ab, input int ag, input int ar);
      pixel_in_type px;
      px.pix_b = PIX_W'(pb);
      px.pix_g = PIX_W'(pg);
      px.pix_r = PIX_W'(pr);
      px.ref_b = REF_W'(ab);
      px.ref_g = REF_W'(ag);
      px.ref_r = REF_W'(ar);
      return px;
   endfunction

   task automatic send_directed();
      int sig;
      int offs[11];
      sig = board.sigma;
      // field extremes, exact match, anchors above range
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0));
      send_pixel(make_pixel(0, 0, 0, 65280, 65280, 65280));
      send_pixel(make_pixel(255, 0, 128, 65535, 65535, 65535));
      send_pixel(make_pixel(128, 255, 0, 16'h8000, 16'hFF00, 16'h0000));
      send_pixel(make_pixel(255, 0, 255, 65280, 65535, 0));
      send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555));
      send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 16'hAAAA, 16'h5555, 16'hAAAA));
      // differences around the threshold, both signs
      offs = '{0, 1, -1, sig / 2, -sig / 2, sig, -sig, sig + 1, -sig - 1,
               3 * sig, -3 * sig};
      foreach (offs[k])
         send_pixel(make_pixel(128, 60, 200,
                               anchor_for_level(128 * 257 + offs[k]),
                               anchor_for_level(60 * 257 - offs[k]),
                               anchor_for_level(200 * 257 + offs[(k + 3) % 11])));
   endtask

   task automatic send_random(input int count);
      pixel_in_type px;
      for (int n = 0; n < count; n++) begin
         px.pix_b = PIX_W'($urandom);
         px.pix_g = PIX_W'($urandom);
         px.pix_r = PIX_W'($urandom);
         px.ref_b = pick_anchor(px.pix_b, board.sigma);
         px.ref_g = pick_anchor(px.pix_g, board.sigma);
         px.ref_r = pick_anchor(px.pix_r, board.sigma);
         send_pixel(px);
      end
   endtask

   initial begin
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SIGMA;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first
      send_directed();
      send_random(PHASE_REQUESTS);

      for (int phase = 1; phase < NUM_PHASES; phase++) begin
         drain_responses();
         case (phase)
            // smallest nonzero threshold and exponent, flat edges
            1: apply_settings(16'd1, 16'd1, 16'd0);
            // everything at its top
            2: apply_settings(16'hFFFF, 16'd31, 16'hFFFF);
            // zero threshold, exponent written with junk above its width
            3: begin
               apply_settings(16'd0, 16'hFFEF, 16'd256);
               write_csr(CSR_SPARE, 16'($urandom));
            end
            // zero exponent
            4: apply_settings(16'd19661, 16'h0020, 16'd512);
            5: apply_settings(16'($urandom_range(1, 2000)), 16'd31, 16'($urandom));
            default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         if (phase == 3)
            send_pixel(make_pixel(0, 128, 255, 0, 16'h8000, 16'hFF00));
         send_random(PHASE_REQUESTS);
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending_count() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
